// ===== design/shamh_pkg.sv =====
// ----------------------------------------------------------------------------
// shamh_pkg: shared types, constants and functions of the SHA-256 hasher
// Sequencer states, control bundles, round constants and initial hash values.
// ----------------------------------------------------------------------------
package shamh_pkg;

    // Padding and block layout
    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [6:0] LENGTH_POS  = 7'd56;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [5:0] LAST_BYTE   = 6'd63;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    // Initial chaining values
    localparam logic [31:0] INIT_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_FOLD,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_EMIT
    } shamh_state_t;

    // Control of the block buffer / schedule window
    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_idx;
        logic [7:0] wr_byte;
        logic       len_en;
        logic       shift;
    } shamh_sched_ctrl_t;

    // Control of the round datapath
    typedef struct packed {
        logic step;
        logic fold;
        logic init;
    } shamh_core_ctrl_t;

    // Rotate right
    function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned k);
        ror32 = (v >> k) | (v << (32 - k));
    endfunction

    // Round constant table
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        round_k = k;
    endfunction

endpackage

// ===== design/shamh_sched.sv =====
// ----------------------------------------------------------------------------
// shamh_sched: block buffer and message schedule window
// Sixteen 32-bit words hold the block bytes big-endian; during compression
// the window shifts once per round and appends the next schedule word.
// ----------------------------------------------------------------------------
module shamh_sched (
    input  logic                         clk,
    input  shamh_pkg::shamh_sched_ctrl_t ctrl,
    input  logic [63:0]                  bit_count,
    output logic [31:0]                  w_cur
);
    import shamh_pkg::*;

    logic [31:0] win_reg [16];
    logic [31:0] w_new;
    logic [31:0] sg0;
    logic [31:0] sg1;

    // Next schedule word from the window taps
    always_comb
    begin
        sg0   = ror32(win_reg[1], 7) ^ ror32(win_reg[1], 18) ^ (win_reg[1] >> 3);
        sg1   = ror32(win_reg[14], 17) ^ ror32(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + sg0 + win_reg[9] + sg1;
    end

    assign w_cur = win_reg[0];

    // Window update: shift, length words, or single byte write
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end
        else if (ctrl.len_en)
        begin
            win_reg[14] <= bit_count[63:32];
            win_reg[15] <= bit_count[31:0];
        end
        else if (ctrl.wr_en)
        begin
            unique case (ctrl.wr_idx[1:0])
                2'd0: win_reg[ctrl.wr_idx[5:2]][31:24] <= ctrl.wr_byte;
                2'd1: win_reg[ctrl.wr_idx[5:2]][23:16] <= ctrl.wr_byte;
                2'd2: win_reg[ctrl.wr_idx[5:2]][15:8]  <= ctrl.wr_byte;
                2'd3: win_reg[ctrl.wr_idx[5:2]][7:0]   <= ctrl.wr_byte;
                default: ;
            endcase
        end
    end

endmodule

// ===== design/shamh_core.sv =====
// ----------------------------------------------------------------------------
// shamh_core: shared round unit with working and chaining registers
// One compression round per step; fold adds the working words into the
// chaining words. Working words mirror the chaining words between blocks.
// ----------------------------------------------------------------------------
module shamh_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  shamh_pkg::shamh_core_ctrl_t ctrl,
    input  logic [5:0]                  round_idx,
    input  logic [31:0]                 w_cur,
    output logic [31:0]                 chain [8]
);
    import shamh_pkg::*;

    logic [31:0] work_reg  [8];
    logic [31:0] chain_reg [8];
    logic [31:0] fold_sum  [8];
    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] choose;
    logic [31:0] major;
    logic [31:0] tmp1;
    logic [31:0] tmp2;

    // Round function
    always_comb
    begin
        big1   = ror32(work_reg[4], 6) ^ ror32(work_reg[4], 11) ^ ror32(work_reg[4], 25);
        choose = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        tmp1   = work_reg[7] + big1 + choose + round_k(round_idx) + w_cur;
        big0   = ror32(work_reg[0], 2) ^ ror32(work_reg[0], 13) ^ ror32(work_reg[0], 22);
        major  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
        tmp2   = big0 + major;
        for (int i = 0; i < 8; i++)
        begin
            fold_sum[i] = chain_reg[i] + work_reg[i];
        end
    end

    // Working and chaining registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i]  <= INIT_WORDS[i];
                chain_reg[i] <= INIT_WORDS[i];
            end
        end
        else if (ctrl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i]  <= INIT_WORDS[i];
                chain_reg[i] <= INIT_WORDS[i];
            end
        end
        else if (ctrl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i]  <= fold_sum[i];
                chain_reg[i] <= fold_sum[i];
            end
        end
        else if (ctrl.step)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + tmp1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= tmp1 + tmp2;
        end
    end

    assign chain = chain_reg;

endmodule

// ===== design/sha256_message_hasher_top.sv =====
// A byte that does not complete a block is only written into the buffer; one that
// completes a block starts the 64 rounds of the shared round unit and the fold.
// Finishing writes the pad bytes one per cycle, with an extra block when the
// length field does not fit; then the digest waits for a free output register.
// No byte is taken outside idle; the single round unit does one round per cycle.
// Reset: chaining words to the initial values, counts zero, no result pending.
// ----------------------------------------------------------------------------
// sha256_message_hasher_top: byte-stream SHA-256 hasher
// Sequencer that loads bytes, pads, runs the round unit and emits the digest.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [63:0] digest_word0,
    output logic [63:0] digest_word1,
    output logic [63:0] digest_word2,
    output logic [63:0] digest_word3
);
    import shamh_pkg::*;

    shamh_state_t      state_reg, state_next;
    shamh_state_t      ret_reg, ret_next;
    logic [6:0]        fill_reg, fill_next;
    logic [63:0]       bits_reg, bits_next;
    logic [5:0]        round_reg, round_next;
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       dig_reg [4];
    logic              load_out;
    shamh_sched_ctrl_t sched_ctrl;
    shamh_core_ctrl_t  core_ctrl;
    logic [31:0]       w_cur;
    logic [31:0]       chain [8];

    shamh_sched u_sched (
        .clk       (clk),
        .ctrl      (sched_ctrl),
        .bit_count (bits_reg),
        .w_cur     (w_cur)
    );

    shamh_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (core_ctrl),
        .round_idx (round_reg),
        .w_cur     (w_cur),
        .chain     (chain)
    );

    assign msg_stall = (state_reg != ST_IDLE);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        round_next = round_reg;
        load_out   = 1'b0;
        sched_ctrl = '0;
        core_ctrl  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (byte_present)
                    begin
                        sched_ctrl.wr_en   = 1'b1;
                        sched_ctrl.wr_idx  = fill_reg[5:0];
                        sched_ctrl.wr_byte = data_byte;
                        bits_next          = bits_reg + BITS_PER_BYTE;
                        if (fill_reg[5:0] == LAST_BYTE)
                        begin
                            fill_next  = '0;
                            round_next = '0;
                            state_next = ST_COMP;
                            ret_next   = end_of_message ? ST_MARK : ST_IDLE;
                        end
                        else
                        begin
                            fill_next = fill_reg + 7'd1;
                            if (end_of_message)
                            begin
                                state_next = ST_MARK;
                            end
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                sched_ctrl.wr_en   = 1'b1;
                sched_ctrl.wr_idx  = fill_reg[5:0];
                sched_ctrl.wr_byte = PAD_MARK;
                fill_next          = fill_reg + 7'd1;
                state_next         = ST_ZERO;
            end
            ST_ZERO:
            begin
                // Zero fill up to the length field, or to the block end first
                if (fill_reg == BLOCK_BYTES)
                begin
                    fill_next  = '0;
                    round_next = '0;
                    state_next = ST_COMP;
                    ret_next   = ST_ZERO;
                end
                else if (fill_reg == LENGTH_POS)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    sched_ctrl.wr_en   = 1'b1;
                    sched_ctrl.wr_idx  = fill_reg[5:0];
                    sched_ctrl.wr_byte = 8'h00;
                    fill_next          = fill_reg + 7'd1;
                end
            end
            ST_LEN:
            begin
                sched_ctrl.len_en = 1'b1;
                fill_next         = '0;
                round_next        = '0;
                state_next        = ST_COMP;
                ret_next          = ST_EMIT;
            end
            ST_COMP:
            begin
                sched_ctrl.shift = 1'b1;
                core_ctrl.step   = 1'b1;
                round_next       = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                core_ctrl.fold = 1'b1;
                state_next     = ret_reg;
            end
            ST_EMIT:
            begin
                // Wait for the output register to free up
                if (!out_valid_reg || !digest_stall)
                begin
                    load_out       = 1'b1;
                    core_ctrl.init = 1'b1;
                    bits_next      = '0;
                    fill_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register handshake
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !digest_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Digest payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dig_reg[i] <= {chain[2 * i], chain[2 * i + 1]};
            end
        end
    end

    assign digest_valid = out_valid_reg;
    assign digest_word0 = dig_reg[0];
    assign digest_word1 = dig_reg[1];
    assign digest_word2 = dig_reg[2];
    assign digest_word3 = dig_reg[3];

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the byte-stream SHA-256 hasher
// Streams messages at most one byte per transfer and predicts every digest with a
// bit-exact software hash. The bench runs in phases that vary pacing on both
// channels, and it adds a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;

    // Pacing of both channels, one value per phase
    typedef enum int {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    // One pending transfer on the message channel
    typedef struct {
        logic [7:0] b;
        logic       present;
        logic       eom;
        pace_t      pace;
        bit         drain_first;   // wait until no digest is outstanding
        bit         hold_out;      // start a long output hold-off
    } msg_item_t;

    // Four digest words; index 3 is digest_word0
    typedef logic [3:0][63:0] digest_t;

    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned TAIL_CYCLES  = 400;
    localparam int unsigned ITEM_TARGET  = 1850;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam int unsigned LEN_OFFSET = 56;
    localparam int unsigned BLK_BYTES  = 64;

    // DUT connections
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;

    // Hash state of the predictor
    logic [31:0] hv [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [63:0] bit_len;

    // Bench bookkeeping
    msg_item_t   pending [$];
    msg_item_t   on_offer;
    digest_t     expected_digests [$];
    pace_t       cur_pace = PACE_FULL;
    logic        hold_kick = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned msgs_queued = 0;
    int unsigned digests_checked = 0;
    int unsigned err_count = 0;
    digest_t     mon_exp;
    digest_t     mon_act;

    sha256_message_hasher_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_stall      (msg_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_stall   (digest_stall),
        .digest_word0   (digest_word0),
        .digest_word1   (digest_word1),
        .digest_word2   (digest_word2),
        .digest_word3   (digest_word3)
    );

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Digest predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rotr(input logic [31:0] v, input int k);
        return (v >> k) | (v << (32 - k));
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++)
        begin
            hv[i] = SHA_H0[i];
        end
        fill    = 0;
        bit_len = 64'd0;
    endfunction

    // 64 rounds over the current block, folded into the chaining words
    function automatic void hash_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
        e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
        hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
    endfunction

    // Apply one accepted transfer; a finished message queues its digest
    function automatic void hash_take(input msg_item_t it);
        if (it.present)
        begin
            bit_len   += 64'd8;
            blk[fill]  = it.b;
            fill++;
            if (fill == BLK_BYTES)
            begin
                hash_compress();
                fill = 0;
            end
        end
        if (it.eom)
        begin
            blk[fill] = PAD_BYTE;
            fill++;
            // no room left for the length field: pad out and run an extra block
            if (fill > LEN_OFFSET)
            begin
                while (fill < BLK_BYTES)
                begin
                    blk[fill] = 8'h00;
                    fill++;
                end
                hash_compress();
                fill = 0;
            end
            while (fill < LEN_OFFSET)
            begin
                blk[fill] = 8'h00;
                fill++;
            end
            for (int i = 0; i < 8; i++)
            begin
                blk[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
            end
            hash_compress();
            expected_digests.push_back({hv[0], hv[1], hv[2], hv[3],
                                        hv[4], hv[5], hv[6], hv[7]});
            hash_restart();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic add_item(input logic [7:0] b, input bit p, input bit e, input pace_t pc,
                            input bit drain, input bit hold);
        msg_item_t it;
        it.b           = b;
        it.present     = p;
        it.eom         = e;
        it.pace        = pc;
        it.drain_first = drain;
        it.hold_out    = hold;
        pending.push_back(it);
        items_queued++;
    endtask

    // Lengths cluster on the padding boundaries, with a few long messages
    function automatic int unsigned pick_len();
        int unsigned edges [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            return edges[$urandom_range(11)];
        end
        else if (r < 95)
        begin
            return $urandom_range(70);
        end
        return $urandom_range(200, 129);
    endfunction

    // One message with random content and some empty transfers mixed in
    task automatic add_message(input int unsigned len, input pace_t pc,
                               input bit drain, input bit hold);
        bit split_end;
        bit d;
        bit h;
        d = drain;
        h = hold;
        split_end = (len == 0) || ($urandom_range(1) == 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 8)
            begin
                add_item(8'($urandom_range(255)), 1'b0, 1'b0, pc, d, h);
                d = 1'b0;
                h = 1'b0;
            end
            add_item(8'($urandom_range(255)), 1'b1, !split_end && (i == len - 1), pc, d, h);
            d = 1'b0;
            h = 1'b0;
        end
        if (split_end)
        begin
            add_item(8'($urandom_range(255)), 1'b0, 1'b1, pc, d, h);
        end
        msgs_queued++;
    endtask

    task automatic add_phase(input pace_t pc, input int unsigned upto,
                             input bit drain, input bit hold);
        add_message(pick_len(), pc, drain, hold);
        while (items_queued < upto)
        begin
            add_message(pick_len(), pc, 1'b0, 1'b0);
        end
    endtask

    function automatic bit sender_idles(input pace_t pc);
        if (pc == PACE_SEND_IDLE)
        begin
            return $urandom_range(99) < 61;
        end
        if (pc == PACE_BOTH)
        begin
            return $urandom_range(99) < 35;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: message channel
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid      <= 1'b0;
            data_byte      <= 8'h00;
            byte_present   <= 1'b0;
            end_of_message <= 1'b0;
            hold_kick      <= 1'b0;
        end
        else
        begin
            if (msg_valid && !msg_stall)
            begin
                hash_take(on_offer);
                items_accepted++;
            end
            if (!msg_valid || !msg_stall)
            begin
                if (pending.size() != 0 &&
                    !(pending[0].drain_first && expected_digests.size() != 0) &&
                    !sender_idles(pending[0].pace))
                begin
                    on_offer        = pending.pop_front();
                    msg_valid      <= 1'b1;
                    data_byte      <= on_offer.b;
                    byte_present   <= on_offer.present;
                    end_of_message <= on_offer.eom;
                    cur_pace       <= on_offer.pace;
                    hold_kick      <= on_offer.hold_out;
                end
                else
                begin
                    msg_valid <= 1'b0;
                    hold_kick <= 1'b0;
                end
            end
            else
            begin
                hold_kick <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: digest stall, with a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_stall <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_kick)
        begin
            digest_stall <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            digest_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else
        begin
            digest_stall <= (cur_pace == PACE_RECV_STALL && $urandom_range(99) < 61) ||
                            (cur_pace == PACE_BOTH && $urandom_range(99) < 35);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each digest transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && digest_valid && !digest_stall)
        begin
            mon_act = {digest_word0, digest_word1, digest_word2, digest_word3};
            if (expected_digests.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected digest, expected none, actual %h", $time, mon_act);
            end
            else
            begin
                mon_exp = expected_digests.pop_front();
                digests_checked++;
                for (int k = 0; k < 4; k++)
                begin
                    if (mon_act[3-k] !== mon_exp[3-k])
                    begin
                        err_count++;
                        $display("%0t: digest_word%0d mismatch, expected %h, actual %h",
                                 $time, k, mon_exp[3-k], mon_act[3-k]);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d digests still outstanding", $time,
                     expected_digests.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, wait for drain, report
    // ------------------------------------------------------------------
    initial
    begin
        hash_restart();

        // Directed: empty transfer, empty message, "abc" both ways,
        // one-byte messages at the byte extremes, empty transfer mid-message
        add_item(8'hff, 1'b0, 1'b0, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h5a, 1'b0, 1'b1, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h61, 1'b1, 1'b0, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h62, 1'b1, 1'b0, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h63, 1'b1, 1'b1, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h61, 1'b1, 1'b0, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h62, 1'b1, 1'b0, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h63, 1'b1, 1'b0, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b1, PACE_FULL, 1'b0, 1'b0);
        add_item(8'hff, 1'b1, 1'b1, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0, PACE_FULL, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0, PACE_FULL, 1'b0, 1'b0);
        add_item(8'hff, 1'b1, 1'b0, PACE_FULL, 1'b0, 1'b0);
        add_item(8'hff, 1'b0, 1'b1, PACE_FULL, 1'b0, 1'b0);
        msgs_queued += 6;

        // Random phases; the first one opens with the long output hold-off,
        // the stall phases start only once all digests are in
        add_phase(PACE_FULL,       ITEM_TARGET / 4,     1'b0, 1'b1);
        add_phase(PACE_SEND_IDLE,  ITEM_TARGET / 2,     1'b0, 1'b0);
        add_phase(PACE_RECV_STALL, ITEM_TARGET * 3 / 4, 1'b1, 1'b0);
        add_phase(PACE_BOTH,       ITEM_TARGET,         1'b1, 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || msg_valid || expected_digests.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb_top: %0d transfers accepted over %0d messages, %0d digests checked",
                 items_accepted, msgs_queued, digests_checked);
        $display("tb_top: pacing phases full, sender idle, receiver stall and both, %0d errors",
                 err_count);
        if (err_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/shamh_pkg.sv
design/shamh_sched.sv
design/shamh_core.sv
design/sha256_message_hasher_top.sv
tb/tb_top.sv
